### design/ctsde_pkg.sv
// ----------------------------------------------------------------------------
// ctsde_pkg
// Types, codes and digit tables shared by the clock time set / encode block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsde_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_NEXT  = 2'd2,
    ACT_LEAVE = 2'd3
  } action_e;

  // Edit mode codes
  localparam logic [1:0] MODE_HOUR   = 2'd0;
  localparam logic [1:0] MODE_MINUTE = 2'd1;
  localparam logic [1:0] MODE_AMPM   = 2'd2;

  // Clock chip register addresses
  localparam logic [1:0] REG_NONE   = 2'd0;
  localparam logic [1:0] REG_MINUTE = 2'd1;
  localparam logic [1:0] REG_HOUR   = 2'd2;

  localparam logic [4:0] HOUR_MAX   = 5'd12;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [7:0] SEG_BLANK  = 8'hFF;

  // Hour byte bit positions
  localparam int unsigned HB_12H = 6;
  localparam int unsigned HB_PM  = 5;

  typedef struct packed {
    action_e    action;
    logic [6:0] load_hour;
    logic [6:0] load_minute;
    logic [6:0] load_second;
  } item_t;

  typedef struct packed {
    logic [7:0] sec_ones;
    logic [7:0] sec_tens;
    logic [7:0] min_ones;
    logic [7:0] min_tens;
    logic [7:0] hour_ones;
    logic [7:0] hour_tens;
  } seg_t;

  typedef struct packed {
    logic       wr_valid;
    logic [1:0] wr_reg;
    logic [6:0] wr_data;
    logic [1:0] mode;
    seg_t       seg;
  } res_t;

  // Ones-digit segment table, blank for a non-digit
  function automatic logic [7:0] seg_low(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h01;
      4'd1:    s = 8'hC7;
      4'd2:    s = 8'h22;
      4'd3:    s = 8'h82;
      4'd4:    s = 8'hC4;
      4'd5:    s = 8'h88;
      4'd6:    s = 8'h08;
      4'd7:    s = 8'hC3;
      4'd8:    s = 8'h00;
      4'd9:    s = 8'hC0;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Tens-digit segment table; a 3-bit digit is always valid
  function automatic logic [7:0] seg_high(input logic [2:0] d);
    logic [7:0] s;
    unique case (d)
      3'd0: s = 8'h80;
      3'd1: s = 8'hB6;
      3'd2: s = 8'h44;
      3'd3: s = 8'h14;
      3'd4: s = 8'h32;
      3'd5: s = 8'h11;
      3'd6: s = 8'h01;
      3'd7: s = 8'hB4;
    endcase
    return s;
  endfunction

  // Binary 0..63 to packed BCD {tens[2:0], ones[3:0]}; d*205>>11 == d/10 here
  function automatic logic [6:0] bin_to_bcd(input logic [5:0] d);
    logic [13:0] prod;
    logic [2:0]  tens;
    logic [5:0]  tens_x10;
    logic [5:0]  ones;
    prod     = {8'd0, d} * 14'd205;
    tens     = prod[13:11];
    tens_x10 = {tens, 3'b000} - {1'b0, tens, 2'b00} + {2'b00, tens, 1'b0}
               + {2'b00, tens, 1'b0} + {2'b00, tens, 1'b0};
    ones     = d - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

### design/ctsde_seg_enc.sv
// ----------------------------------------------------------------------------
// ctsde_seg_enc
// Seven-segment codes for the six time digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsde_seg_enc import ctsde_pkg::*; (
  input  logic [6:0] hour_i,
  input  logic [6:0] minute_i,
  input  logic [6:0] second_i,
  output seg_t       seg_o
);

  logic [2:0] hour_tens;

  // 12-hour mode: only bit 4 is the tens digit
  assign hour_tens = hour_i[HB_12H] ? {2'b00, hour_i[4]} : hour_i[6:4];

  assign seg_o.sec_ones  = seg_low(second_i[3:0]);
  assign seg_o.sec_tens  = seg_high(second_i[6:4]);
  assign seg_o.min_ones  = seg_low(minute_i[3:0]);
  assign seg_o.min_tens  = seg_high(minute_i[6:4]);
  assign seg_o.hour_ones = seg_low(hour_i[3:0]);
  assign seg_o.hour_tens = seg_high(hour_tens);

endmodule

`default_nettype wire

### design/ctsde_core.sv
// ----------------------------------------------------------------------------
// ctsde_core
// Time bytes and edit mode; applies one item per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsde_core import ctsde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output res_t  res_o
);

  logic [6:0] hour_q, hour_d;
  logic [6:0] minute_q, minute_d;
  logic [6:0] second_q, second_d;
  logic [1:0] mode_q, mode_d;

  logic [6:0] min_sum;
  logic [6:0] min_bcd;
  logic [4:0] hour_sum;
  logic [6:0] hour_bcd;
  seg_t       seg;
  logic       wr_valid;
  logic [1:0] wr_reg;
  logic [6:0] wr_data;

  // Minute: tens*10 + ones + 1, nibbles taken as given
  always_comb begin
    min_sum = {1'b0, minute_q[6:4], 3'b000} + {3'b000, minute_q[6:4], 1'b0}
              + {3'b000, minute_q[3:0]} + 7'd1;
    if (min_sum > MINUTE_MAX) begin
      min_sum = 7'd0;
    end
    min_bcd = bin_to_bcd(min_sum[5:0]);
  end

  // Hour: bit4*10 + low nibble + 1, wraps to 1 above 12
  always_comb begin
    hour_sum = (hour_q[4] ? 5'd10 : 5'd0) + {1'b0, hour_q[3:0]} + 5'd1;
    if (hour_sum > HOUR_MAX) begin
      hour_sum = 5'd1;
    end
    hour_bcd = bin_to_bcd({1'b0, hour_sum});
  end

  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    mode_d   = mode_q;
    wr_valid = 1'b0;
    wr_reg   = REG_NONE;
    wr_data  = 7'd0;
    if (en_i) begin
      unique case (item_i.action)
        ACT_LOAD: begin
          hour_d   = item_i.load_hour;
          minute_d = item_i.load_minute;
          second_d = item_i.load_second;
        end
        ACT_SET: begin
          wr_valid = 1'b1;
          priority if (mode_q == MODE_MINUTE) begin
            minute_d = min_bcd;
            wr_reg   = REG_MINUTE;
            wr_data  = min_bcd;
          end else if (mode_q == MODE_AMPM) begin
            hour_d        = hour_q;
            hour_d[HB_PM] = ~hour_q[HB_PM];
            wr_reg        = REG_HOUR;
            wr_data       = hour_d;
          end else begin
            hour_d  = {1'b1, hour_q[HB_PM], hour_bcd[4:0]};
            wr_reg  = REG_HOUR;
            wr_data = hour_d;
          end
        end
        ACT_NEXT: begin
          priority if (mode_q == MODE_HOUR) begin
            mode_d = MODE_MINUTE;
          end else if (mode_q == MODE_MINUTE) begin
            mode_d = MODE_AMPM;
          end else begin
            mode_d = MODE_HOUR;
          end
        end
        ACT_LEAVE: begin
          mode_d = MODE_HOUR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= 7'd0;
      minute_q <= 7'd0;
      second_q <= 7'd0;
      mode_q   <= MODE_HOUR;
    end else begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      mode_q   <= mode_d;
    end
  end

  ctsde_seg_enc u_seg_enc (
    .hour_i   (hour_d),
    .minute_i (minute_d),
    .second_i (second_d),
    .seg_o    (seg)
  );

  assign res_o = {wr_valid, wr_reg, wr_data, mode_d, seg};

endmodule

`default_nettype wire

### design/clock_time_set_and_digit_encode.sv
// ----------------------------------------------------------------------------
// clock_time_set_and_digit_encode
// 12-hour BCD time setting with register write-back and seven-segment codes.
//
//   channel | valid / ready          | payload
//   --------+------------------------+----------------------------------------
//   in      | in_valid_i/in_ready_o  | action, load_hour/minute/second
//   out     | out_valid_o/out_ready_i| write_*, edit_mode, seg_* (six codes)
//
// One item per cycle sustained while the output is not stalled. An item sits
// in the input register, is applied to the time bytes, and its result lands in
// the output register. A stalled output holds the input register; the input
// still takes an item whenever the input register is empty or the output
// register is free or being drained.
// Reset clears time bytes and edit mode.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_set_and_digit_encode import ctsde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [6:0] load_hour_i,
  input  logic [6:0] load_minute_i,
  input  logic [6:0] load_second_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       write_valid_o,
  output logic [1:0] write_register_o,
  output logic [6:0] write_data_o,
  output logic [1:0] edit_mode_o,
  output logic [7:0] seg_sec_ones_o,
  output logic [7:0] seg_sec_tens_o,
  output logic [7:0] seg_min_ones_o,
  output logic [7:0] seg_min_tens_o,
  output logic [7:0] seg_hour_ones_o,
  output logic [7:0] seg_hour_tens_o
);

  logic  in_vld_q;
  item_t item_q;
  logic  out_vld_q;
  res_t  res_q;
  res_t  res;
  logic  out_free;
  logic  advance;

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action      <= action_e'(action_i);
      item_q.load_hour   <= load_hour_i;
      item_q.load_minute <= load_minute_i;
      item_q.load_second <= load_second_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  ctsde_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .res_o  (res)
  );

  assign out_valid_o      = out_vld_q;
  assign write_valid_o    = res_q.wr_valid;
  assign write_register_o = res_q.wr_reg;
  assign write_data_o     = res_q.wr_data;
  assign edit_mode_o      = res_q.mode;
  assign seg_sec_ones_o   = res_q.seg.sec_ones;
  assign seg_sec_tens_o   = res_q.seg.sec_tens;
  assign seg_min_ones_o   = res_q.seg.min_ones;
  assign seg_min_tens_o   = res_q.seg.min_tens;
  assign seg_hour_ones_o  = res_q.seg.hour_ones;
  assign seg_hour_tens_o  = res_q.seg.hour_tens;

  // A waiting item is never dropped while the output is stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q)
    else $error("input item lost while stalled");

  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |->
      (write_register_o == REG_MINUTE || write_register_o == REG_HOUR))
    else $error("write without a register address");

  a_no_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |->
      (write_register_o == REG_NONE && write_data_o == 7'd0))
    else $error("register fields set without a write");

  a_mode_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> edit_mode_o != 2'd3)
    else $error("edit mode out of range");

endmodule

`default_nettype wire

### sim/clock_time_set_and_digit_encode_test.sv
// ----------------------------------------------------------------------------
// clock_time_set_and_digit_encode_test
// Self-checking bench: drives load / set / next / leave transfers through the
// valid-ready input, keeps its own copy of the time bytes and edit mode, and
// checks every output transfer, field by field, against the predicted write
// and seven-segment codes.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_set_and_digit_encode_test;
  import ctsde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_e    act;
    logic [6:0] hr;
    logic [6:0] mn;
    logic [6:0] sc;
    logic       drain;   // hold off until every result is back
  } stim_t;

  // Segment codes, digit 0 in the low byte
  localparam logic [79:0] ONES_SEG = {8'hC0, 8'h00, 8'hC3, 8'h08, 8'h88,
                                      8'hC4, 8'h82, 8'h22, 8'hC7, 8'h01};
  localparam logic [79:0] TENS_SEG = {8'h30, 8'h00, 8'hB4, 8'h01, 8'h11,
                                      8'h32, 8'h14, 8'h44, 8'hB6, 8'h80};

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       out_ready = 1'b0;
  action_e    action = ACT_LOAD;
  logic [6:0] load_hour = '0;
  logic [6:0] load_minute = '0;
  logic [6:0] load_second = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       write_valid_o;
  logic [1:0] write_register_o;
  logic [6:0] write_data_o;
  logic [1:0] edit_mode_o;
  logic [7:0] seg_sec_ones_o;
  logic [7:0] seg_sec_tens_o;
  logic [7:0] seg_min_ones_o;
  logic [7:0] seg_min_tens_o;
  logic [7:0] seg_hour_ones_o;
  logic [7:0] seg_hour_tens_o;

  stim_t stim_q[$];
  res_t  readouts[$];

  // Predicted clock state
  logic [6:0] clk_hour = '0;
  logic [6:0] clk_min = '0;
  logic [6:0] clk_sec = '0;
  logic [1:0] edit_sel = MODE_HOUR;

  int errors = 0;
  int cycle = 0;
  int hold_left = 0;
  logic quiet;

  assign quiet = (cycle >= 500) && (cycle < 800);

  clock_time_set_and_digit_encode DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .action_i        (action),
    .load_hour_i     (load_hour),
    .load_minute_i   (load_minute),
    .load_second_i   (load_second),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .write_valid_o   (write_valid_o),
    .write_register_o(write_register_o),
    .write_data_o    (write_data_o),
    .edit_mode_o     (edit_mode_o),
    .seg_sec_ones_o  (seg_sec_ones_o),
    .seg_sec_tens_o  (seg_sec_tens_o),
    .seg_min_ones_o  (seg_min_ones_o),
    .seg_min_tens_o  (seg_min_tens_o),
    .seg_hour_ones_o (seg_hour_ones_o),
    .seg_hour_tens_o (seg_hour_tens_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL clock_time_set_and_digit_encode");
    $finish;
  end

  function automatic logic [6:0] to_bcd7(input int v);
    logic [6:0] b;
    b[6:4] = 3'(v / 10);
    b[3:0] = 4'(v % 10);
    return b;
  endfunction

  function automatic logic [7:0] ones_code(input logic [3:0] nib);
    return (nib > 4'd9) ? SEG_BLANK : ONES_SEG[nib * 8 +: 8];
  endfunction

  function automatic logic [7:0] tens_code(input logic [2:0] nib);
    return TENS_SEG[nib * 8 +: 8];
  endfunction

  // Apply one transfer to the predicted clock and return its readout
  function automatic res_t apply_press(input action_e a, input logic [6:0] h,
                                       input logic [6:0] m, input logic [6:0] s);
    res_t       r;
    int         d;
    logic [6:0] hb;
    logic [2:0] ht;
    r = '0;
    case (a)
      ACT_LOAD: begin
        clk_hour = h;
        clk_min  = m;
        clk_sec  = s;
      end
      ACT_SET: begin
        r.wr_valid = 1'b1;
        case (edit_sel)
          MODE_MINUTE: begin
            d = 10 * int'(clk_min[6:4]) + int'(clk_min[3:0]) + 1;
            if (d > 59) d = 0;
            clk_min  = to_bcd7(d);
            r.wr_reg = REG_MINUTE;
            r.wr_data = clk_min;
          end
          MODE_AMPM: begin
            clk_hour[HB_PM] = ~clk_hour[HB_PM];
            r.wr_reg = REG_HOUR;
            r.wr_data = clk_hour;
          end
          default: begin
            // bit 4 is the only hour tens bit; ones nibble taken as given
            d = 10 * int'(clk_hour[4]) + int'(clk_hour[3:0]) + 1;
            if (d > 12) d = 1;
            hb = to_bcd7(d);
            clk_hour = {1'b1, clk_hour[HB_PM], hb[4:0]};
            r.wr_reg = REG_HOUR;
            r.wr_data = clk_hour;
          end
        endcase
      end
      ACT_NEXT: begin
        edit_sel = (edit_sel == MODE_HOUR)   ? MODE_MINUTE :
                   (edit_sel == MODE_MINUTE) ? MODE_AMPM : MODE_HOUR;
      end
      default: edit_sel = MODE_HOUR;
    endcase
    ht = clk_hour[HB_12H] ? {2'b00, clk_hour[4]} : clk_hour[6:4];
    r.mode          = edit_sel;
    r.seg.sec_ones  = ones_code(clk_sec[3:0]);
    r.seg.sec_tens  = tens_code(clk_sec[6:4]);
    r.seg.min_ones  = ones_code(clk_min[3:0]);
    r.seg.min_tens  = tens_code(clk_min[6:4]);
    r.seg.hour_ones = ones_code(clk_hour[3:0]);
    r.seg.hour_tens = tens_code(ht);
    return r;
  endfunction

  function automatic void add_item(input action_e a, input logic [6:0] h,
                                   input logic [6:0] m, input logic [6:0] s,
                                   input logic drain = 1'b0);
    stim_t t;
    t.act = a;
    t.hr = h;
    t.mn = m;
    t.sc = s;
    t.drain = drain;
    stim_q.push_back(t);
  endfunction

  // Button press; the load fields are don't-care and get random content
  function automatic void add_press(input action_e a);
    add_item(a, 7'($urandom), 7'($urandom), 7'($urandom));
  endfunction

  function automatic logic [6:0] valid_hour();
    logic [6:0] b;
    if ($urandom_range(0, 1) == 1) begin
      b = to_bcd7($urandom_range(1, 12));
      b[HB_12H] = 1'b1;
      b[HB_PM] = ($urandom_range(0, 1) == 1);
    end else begin
      b = to_bcd7($urandom_range(0, 23));
    end
    return b;
  endfunction

  function automatic void add_valid_load();
    add_item(ACT_LOAD, valid_hour(), to_bcd7($urandom_range(0, 59)),
             to_bcd7($urandom_range(0, 59)));
  endfunction

  // A user editing session: fresh time, then a run of presses and reloads
  function automatic void add_session();
    int steps;
    int pick;
    add_valid_load();
    steps = $urandom_range(3, 15);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      add_press(ACT_SET);
      else if (pick < 80) add_press(ACT_NEXT);
      else if (pick < 88) add_press(ACT_LEAVE);
      else                add_valid_load();
    end
    if ($urandom_range(0, 9) < 7) add_press(ACT_LEAVE);
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      add_item(action_e'($urandom_range(0, 3)), 7'($urandom), 7'($urandom), 7'($urandom));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) cycle <= cycle + 1;
  end

  // Long output back-pressure windows so the input side fills and stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (cycle == 250 || cycle == 1100) begin
      hold_left <= 80;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk_i) begin : driver
    stim_t nxt;
    logic  idle;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o)
        readouts.push_back(apply_press(action, load_hour, load_minute, load_second));
      if (!in_valid || in_ready_o) begin
        idle = quiet ? 1'b0 : ($urandom_range(0, 99) < 18);
        if (stim_q.size() == 0 || idle || (stim_q[0].drain && readouts.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = stim_q.pop_front();
          in_valid    <= 1'b1;
          action      <= nxt.act;
          load_hour   <= nxt.hr;
          load_minute <= nxt.mn;
          load_second <= nxt.sc;
        end
      end
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (readouts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: result transfer with nothing expected");
      end else begin
        want = readouts.pop_front();
        check_field("write_valid", want.wr_valid, write_valid_o);
        check_field("write_register", want.wr_reg, write_register_o);
        check_field("write_data", want.wr_data, write_data_o);
        check_field("edit_mode", want.mode, edit_mode_o);
        check_field("seg_sec_ones", want.seg.sec_ones, seg_sec_ones_o);
        check_field("seg_sec_tens", want.seg.sec_tens, seg_sec_tens_o);
        check_field("seg_min_ones", want.seg.min_ones, seg_min_ones_o);
        check_field("seg_min_tens", want.seg.min_tens, seg_min_tens_o);
        check_field("seg_hour_ones", want.seg.hour_ones, seg_hour_ones_o);
        check_field("seg_hour_tens", want.seg.hour_tens, seg_hour_tens_o);
      end
    end
  end

  initial begin
    // Directed: hour wrap 12 -> 1, minute wrap, PM toggle, mode wrap,
    // load while editing, non-digit nibbles, 24-hour hour tens
    add_item(ACT_LOAD, 7'h52, 7'h59, 7'h59);
    add_press(ACT_SET);
    add_press(ACT_SET);
    add_press(ACT_NEXT);
    add_press(ACT_SET);
    add_item(ACT_LOAD, 7'h00, 7'h7F, 7'h7F);
    add_press(ACT_SET);
    add_press(ACT_NEXT);
    add_press(ACT_SET);
    add_press(ACT_SET);
    add_press(ACT_NEXT);
    add_item(ACT_LOAD, 7'h1F, 7'h00, 7'h00);
    add_press(ACT_SET);
    add_item(ACT_LOAD, 7'h3F, 7'h0A, 7'h7A);
    add_item(ACT_LOAD, 7'h7F, 7'h7F, 7'h7F);
    add_press(ACT_SET);
    add_item(ACT_LOAD, 7'h51, 7'h30, 7'h45);
    add_press(ACT_SET);
    add_press(ACT_NEXT);
    add_press(ACT_LEAVE);
    add_press(ACT_LEAVE);
    add_item(ACT_LOAD, 7'h00, 7'h00, 7'h00);
    add_press(ACT_NEXT);
    add_press(ACT_NEXT);
    add_press(ACT_NEXT);

    // Random part; the first random transfer waits for the pipe to drain
    add_item(ACT_LOAD, valid_hour(), to_bcd7($urandom_range(0, 59)),
             to_bcd7($urandom_range(0, 59)), 1'b1);
    while (stim_q.size() < 875) begin
      if ($urandom_range(0, 99) < 75) add_session();
      else add_noise();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk_i);
    while (readouts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS clock_time_set_and_digit_encode");
    end else begin
      $display("FAIL clock_time_set_and_digit_encode");
    end
    $finish;
  end

endmodule

`default_nettype wire

### clock_time_set_and_digit_encode.f
design/ctsde_pkg.sv
design/ctsde_seg_enc.sv
design/ctsde_core.sv
design/clock_time_set_and_digit_encode.sv
sim/clock_time_set_and_digit_encode_test.sv
